### design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared widths, stage codes, register indexes and the exponential table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adsr_pkg;

  // Sample and time formats.
  localparam int SAMPLE_WIDTH    = 16;
  localparam int TIME_W          = 29;                   // Q5.24
  localparam int COEF_W          = 25;                   // Q1.24, 1.0 included
  localparam int SUS_W           = 17;                   // Q1.16, 1.0 included
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH);
  localparam int FRAC_W          = TIME_W - IDX_W;
  localparam int ROM_AW          = IDX_W + 1;
  localparam int MUL_W           = COEF_W + 1;

  localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
  localparam logic [COEF_W-1:0] ONE_Q24     = COEF_W'(1) << 24;
  localparam logic [COEF_W-1:0] ATTACK_END  = COEF_W'(16777);
  localparam logic [COEF_W-1:0] RELEASE_END = COEF_W'(17);
  localparam logic [SUS_W-1:0]  SUS_ONE     = SUS_W'(65536);

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  // Envelope stage codes as they appear on the output.
  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  typedef logic [COEF_W-1:0] rom_t [EXP_TABLE_DEPTH+1];

  // Q.31 product with round half up.
  function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
    mul_q31 = (a * b + (64'd1 << 30)) >> 31;
  endfunction

  // Unsigned quotient by restoring shift and subtract, used at elaboration.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], num[j]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[j] = 1'b1;
      end
    end
    div_u64 = quo;
  endfunction

  // Table of exp(-32*i/depth) in Q1.24, built at elaboration.
  function automatic rom_t build_rom();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] base;
    logic [31:0] n;
    logic        done;
    rom_t        rom;
    term = 64'd1 << 56;
    pos  = term;
    neg  = 64'd0;
    done = 1'b0;
    // Taylor series of exp(-32/depth) in Q.56.
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        term = div_u64(term * 64'd32, 64'(EXP_TABLE_DEPTH) * 64'(k));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (k % 2 == 1) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    r = ((pos - neg) + (64'd1 << 24)) >> 25;
    // Powers by square and multiply, then rounded to Q1.24.
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      v    = 64'd1 << 31;
      base = r;
      n    = 32'(i);
      for (int b = 0; b < 14; b++) begin
        if (n[b]) begin
          v = mul_q31(v, base);
        end
        base = mul_q31(base, base);
      end
      rom[i] = COEF_W'((v + 64'd64) >> 7);
    end
    build_rom = rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

endpackage

### design/adsr_if.sv
// ----------------------------------------------------------------------------
// ADSR envelope channel interfaces
// Valid/ready interfaces for the input, output and configuration channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Input channel: one operation word.
interface adsr_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output op, output in_sample, input ready);
  modport sink   (input valid, input op, input in_sample, output ready);
endinterface

// Output channel: one enveloped sample word.
interface adsr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [adsr_pkg::SAMPLE_WIDTH-1:0] out_sample;
  logic [2:0]                         stage_after;

  modport source (output valid, output out_sample, output stage_after, input ready);
  modport sink   (input valid, input out_sample, input stage_after, output ready);
endinterface

// Configuration write channel.
interface adsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [28:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Scales an audio stream by an exponential attack/decay/sustain/release gain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries words with an op code: an audio sample, note on or note off.
//   Note on restarts attack and note off starts release; neither gives a word
//   on out_o. Each audio sample gives exactly one word on out_o with the scaled
//   sample and the stage reached after it.
//   cfg_i writes the four step/level registers; it is always ready and should
//   only be used while no sample is in flight.
//   An audio sample is accepted in idle, then steps through COEF, GAIN, SCALE
//   and RES (interpolation, release gain and sample scaling in the single
//   26x26 shared multiplier, then result load). A new sample or note word is
//   taken only once the sequencer is back in idle.
//   in_i stays ready while a finished result waits in the output register; a
//   sample only blocks if it must load its result while the previous one is
//   still stalled by out_o.ready.
//   Reset puts the envelope in idle with time zero, steps at zero and the
//   sustain level at 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_envelope_generator (
  input  logic          clk_i,
  input  logic          rst_ni,
  adsr_in_if.sink       in_i,
  adsr_out_if.source    out_o,
  adsr_cfg_if.sink      cfg_i
);
  import adsr_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    SEQ_IDLE  = 5'b00001,
    SEQ_COEF  = 5'b00010,
    SEQ_GAIN  = 5'b00100,
    SEQ_SCALE = 5'b01000,
    SEQ_RES   = 5'b10000
  } seq_e;

  seq_e                         seq_q, seq_d;
  logic [TIME_W-1:0]            attack_step_q, decay_step_q, release_step_q;
  logic [SUS_W-1:0]             sustain_q;
  stage_e                       stage_q, stage_d;
  stage_e                       eff_q, eff_d;
  logic [TIME_W-1:0]            time_q, time_d;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic [COEF_W-1:0]            rom_a_q;
  logic [COEF_W-1:0]            coef_q;
  logic signed [2*MUL_W-1:0]    mul_q;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic                         out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  stage_e                       out_stage_q;

  logic                         in_acc;
  logic [SUS_W-1:0]             sus;
  logic [IDX_W-1:0]             rom_idx;
  logic [COEF_W-1:0]            rom_a, rom_b;
  logic [COEF_W-1:0]            coef;
  logic [COEF_W-1:0]            gain;
  logic [TIME_W:0]              time_sum;
  logic [TIME_W-1:0]            time_adv;
  logic [TIME_W-1:0]            step_sel;
  logic                         res_load;

  assign in_acc   = in_i.valid && in_i.ready;
  assign sus      = (sustain_q > SUS_ONE) ? SUS_ONE : sustain_q;
  assign res_load = (seq_q == SEQ_RES) && (!out_valid_q || out_o.ready);

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_step_q  <= '0;
      decay_step_q   <= '0;
      sustain_q      <= SUS_ONE;
      release_step_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ATTACK:  attack_step_q  <= cfg_i.data;
        CFG_DECAY:   decay_step_q   <= cfg_i.data;
        CFG_SUSTAIN: sustain_q      <= cfg_i.data[SUS_W-1:0];
        CFG_RELEASE: release_step_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Table lookup at the current time point.
  assign rom_idx = time_q[TIME_W-1 -: IDX_W];
  assign rom_a   = EXP_ROM[ROM_AW'(rom_idx)];
  assign rom_b   = EXP_ROM[ROM_AW'(rom_idx) + ROM_AW'(1)];
  assign coef    = rom_a_q - COEF_W'(mul_q >>> FRAC_W);

  // Gain for the effective stage: registered coefficient, sustain level or release product.
  always_comb begin
    case (eff_q)
      STG_ATTACK:  gain = ONE_Q24 - coef_q;
      STG_DECAY:   gain = coef_q;
      STG_SUSTAIN: gain = {sus, 8'd0};
      STG_RELEASE: gain = mul_q[COEF_W+15:16];
      default:     gain = '0;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (seq_q)
      SEQ_COEF: begin
        mul_a = MUL_W'(rom_a - rom_b);
        mul_b = MUL_W'(time_q[FRAC_W-1:0]);
      end
      SEQ_GAIN: begin
        mul_a = MUL_W'(sus);
        mul_b = MUL_W'(coef);
      end
      SEQ_SCALE: begin
        mul_a = MUL_W'(sample_q);
        mul_b = MUL_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating time advance for the effective stage.
  always_comb begin
    case (eff_q)
      STG_ATTACK: step_sel = attack_step_q;
      STG_DECAY:  step_sel = decay_step_q;
      default:    step_sel = release_step_q;
    endcase
  end
  assign time_sum = {1'b0, time_q} + {1'b0, step_sel};
  assign time_adv = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];

  // Sequencer and envelope state.
  always_comb begin
    seq_d   = seq_q;
    stage_d = stage_q;
    eff_d   = eff_q;
    time_d  = time_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          case (op_e'(in_i.op))
            OP_NOTE_ON: begin
              stage_d = STG_ATTACK;
              time_d  = '0;
            end
            OP_NOTE_OFF: begin
              stage_d = STG_RELEASE;
              time_d  = '0;
            end
            OP_SAMPLE: begin
              seq_d = SEQ_COEF;
              // Stages with a zero step are passed through at once.
              eff_d = stage_q;
              if (stage_q == STG_ATTACK && attack_step_q == '0) begin
                eff_d = STG_DECAY;
              end
              if ((stage_q == STG_DECAY || (stage_q == STG_ATTACK && attack_step_q == '0))
                  && decay_step_q == '0) begin
                eff_d = STG_SUSTAIN;
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_COEF: seq_d = SEQ_GAIN;
      SEQ_GAIN: seq_d = SEQ_SCALE;
      SEQ_SCALE: begin
        seq_d   = SEQ_RES;
        stage_d = eff_q;
        case (eff_q)
          STG_ATTACK: begin
            if (coef_q <= ATTACK_END) begin
              stage_d = STG_DECAY;
              time_d  = '0;
            end else begin
              time_d = time_adv;
            end
          end
          STG_DECAY: begin
            if (coef_q < {sus, 8'd0}) begin
              stage_d = STG_SUSTAIN;
              time_d  = '0;
            end else begin
              time_d = time_adv;
            end
          end
          STG_RELEASE: begin
            if (release_step_q == '0 || coef_q < RELEASE_END) begin
              stage_d = STG_IDLE;
              time_d  = '0;
            end else begin
              time_d = time_adv;
            end
          end
          STG_SUSTAIN: ;
          default: stage_d = STG_IDLE;
        endcase
      end
      SEQ_RES: begin
        if (res_load) begin
          seq_d = SEQ_IDLE;
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SEQ_IDLE;
      stage_q <= STG_IDLE;
      eff_q   <= STG_IDLE;
      time_q  <= '0;
    end else begin
      seq_q   <= seq_d;
      stage_q <= stage_d;
      eff_q   <= eff_d;
      time_q  <= time_d;
    end
  end

  // Datapath registers around the shared multiplier. The product is held
  // while a finished result waits for the output register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.in_sample;
    end
    if (seq_q == SEQ_COEF) begin
      rom_a_q <= rom_a;
    end
    if (seq_q == SEQ_GAIN) begin
      coef_q <= coef;
    end
    if (seq_q == SEQ_COEF || seq_q == SEQ_GAIN || seq_q == SEQ_SCALE) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_sample_q <= SAMPLE_WIDTH'(mul_q >>> 24);
      out_stage_q  <= stage_q;
    end
  end

  assign in_i.ready        = (seq_q == SEQ_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.out_sample  = out_sample_q;
  assign out_o.stage_after = out_stage_q;

endmodule

### design/adsr_checker.sv
// ----------------------------------------------------------------------------
// ADSR envelope port checker
// Watches the top level's channels over time and reports violations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_op_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       cfg_ready_i
);
  import adsr_pkg::*;

  // A stalled output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  // An accepted audio sample occupies the sequencer for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_SAMPLE |=> !in_ready_i)
    else $error("input ready right after an audio sample");

  // A new output word is only loaded while the sequencer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("output word appeared without a sample in progress");

  // Note words and ignored words never produce an output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i != OP_SAMPLE && !out_valid_i |=> !out_valid_i)
    else $error("output word produced by a note word");

  // The configuration channel never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cfg_ready_i (cfg_i.ready)
);
